### hdl/scd_pkg.sv
package scd_pkg;

  // Word layout
  localparam int unsigned LAT_W       = 24;
  localparam int unsigned LON_W       = 25;
  localparam int unsigned ANG_W       = 26;
  localparam int unsigned CHORD_W     = 22;
  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 24;

  // Signed Q30 value, range -2^30 .. 2^30
  typedef logic signed [31:0] q30_t;

  // 90 degrees in degrees*65536
  localparam logic [ANG_W-1:0] POLAR_OFS = 26'd5898240;

  // round(0.0174533 * 2^40) split as K_HI * 2^18 + K_LO
  localparam logic [16:0]  RAD_K_HI  = 17'd73204;
  localparam logic [16:0]  RAD_K_LO  = 17'd116917;
  localparam int unsigned  RAD_SPLIT = 18;

  // pi/2 in Q30 and the quadrant decision points
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned     QUAD_EDGES  = 6;
  localparam logic [33:0] QUAD_EDGE [QUAD_EDGES] = '{
    34'(1 * HALF_PI_Q30 - HALF_PI_Q30 / 2),
    34'(2 * HALF_PI_Q30 - HALF_PI_Q30 / 2),
    34'(3 * HALF_PI_Q30 - HALF_PI_Q30 / 2),
    34'(4 * HALF_PI_Q30 - HALF_PI_Q30 / 2),
    34'(5 * HALF_PI_Q30 - HALF_PI_Q30 / 2),
    34'(6 * HALF_PI_Q30 - HALF_PI_Q30 / 2)
  };
  localparam logic [33:0] QUAD_BASE [8] = '{
    34'(0),
    34'(1 * HALF_PI_Q30),
    34'(2 * HALF_PI_Q30),
    34'(3 * HALF_PI_Q30),
    34'(4 * HALF_PI_Q30),
    34'(5 * HALF_PI_Q30),
    34'(6 * HALF_PI_Q30),
    34'(7 * HALF_PI_Q30)
  };

  localparam logic [30:0] Q_ONE = 31'h4000_0000;

  // Series steps: floor(v / d) == (v * RECIP) >> SHIFT for every v below 2^30
  localparam int unsigned HORNER_STEPS = 7;
  localparam logic [30:0] SIN_RECIP [HORNER_STEPS-1] = '{
    31'd1762037866, 31'd1249445032, 31'd1908874354,
    31'd1636178018, 31'd1717986919, 31'd1431655766
  };
  localparam int unsigned SIN_SHIFT [HORNER_STEPS-1] = '{38, 37, 37, 36, 35, 33};
  localparam logic [30:0] COS_RECIP [HORNER_STEPS] = '{
    31'd1510318171, 31'd2082408386, 31'd1527099484, 31'd1227133514,
    31'd1145324613, 31'd1431655766, 31'd1073741824
  };
  localparam int unsigned COS_SHIFT [HORNER_STEPS] = '{38, 38, 37, 36, 35, 34, 31};

  // Stage counts
  localparam int unsigned SC_LAT     = 5 + 2 * HORNER_STEPS + 1;
  localparam int unsigned ROOT_W     = 32;
  localparam int unsigned SQ_LAT     = ROOT_W;
  localparam int unsigned PIPE_DEPTH = 1 + SC_LAT + 3 + SQ_LAT + 2;

  // Output scaling: (q * 6356752 + 2097152000) / (1000 * 2^22)
  localparam logic [22:0] OUT_SCALE = 23'd6356752;
  localparam logic [31:0] OUT_BIAS  = 32'd2097152000;
  localparam logic [30:0] OUT_RECIP = 31'd1099511628;
  localparam int unsigned OUT_SHIFT = 37;
  localparam logic [CHORD_W-1:0] CHORD_MAX = '1;

endpackage

### hdl/scd_sincos.sv
module scd_sincos (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [scd_pkg::ANG_W-1:0]  angle_i,
  output scd_pkg::q30_t                     sin_o,
  output scd_pkg::q30_t                     cos_o
);

  localparam int unsigned NS = scd_pkg::HORNER_STEPS;

  localparam logic [1:0] QUAD_REF   = 2'd0;
  localparam logic [1:0] QUAD_LEFT  = 2'd1;
  localparam logic [1:0] QUAD_BACK  = 2'd2;
  localparam logic [1:0] QUAD_RIGHT = 2'd3;

  typedef struct packed {
    logic [29:0] x2;
    logic [29:0] u;
    logic        sneg;
    logic [1:0]  quad;
  } side_t;

  // Degrees to Q30 radians, split product
  logic [scd_pkg::ANG_W-1:0] mag_d;
  logic [42:0] pp_hi_d, pp_lo_d, pp_hi_q, pp_lo_q;
  logic        neg0_q;

  assign mag_d   = angle_i[scd_pkg::ANG_W-1] ? scd_pkg::ANG_W'(-angle_i)
                                             : scd_pkg::ANG_W'(angle_i);
  assign pp_hi_d = 43'(mag_d) * 43'(scd_pkg::RAD_K_HI);
  assign pp_lo_d = 43'(mag_d) * 43'(scd_pkg::RAD_K_LO);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_hi_q <= pp_hi_d;
      pp_lo_q <= pp_lo_d;
      neg0_q  <= angle_i[scd_pkg::ANG_W-1];
    end
  end

  logic [60:0] rad_sum_d;
  logic [33:0] rad_q;
  logic        neg1_q;

  assign rad_sum_d = (61'(pp_hi_q) << scd_pkg::RAD_SPLIT) + 61'(pp_lo_q)
                   + (61'(1) << 25);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_sum_d[59:26];
      neg1_q <= neg0_q;
    end
  end

  // Quadrant count
  logic [2:0]  n_d, n_q;
  logic [33:0] rad2_q;
  logic        neg2_q;

  always_comb begin
    n_d = '0;
    for (int k = 0; k < scd_pkg::QUAD_EDGES; k++) begin
      if (rad_q >= scd_pkg::QUAD_EDGE[k]) begin
        n_d = n_d + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= n_d;
      rad2_q <= rad_q;
      neg2_q <= neg1_q;
    end
  end

  // Remainder in [-pi/4, pi/4]
  logic [33:0] base_d;
  logic        rneg_d;
  logic [33:0] diff_d;
  logic [29:0] u3_q;
  logic        sneg3_q;
  logic [1:0]  quad3_q;

  assign base_d = scd_pkg::QUAD_BASE[n_q];
  assign rneg_d = rad2_q < base_d;
  assign diff_d = rneg_d ? (base_d - rad2_q) : (rad2_q - base_d);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u3_q    <= diff_d[29:0];
      sneg3_q <= rneg_d ^ neg2_q;
      quad3_q <= neg2_q ? (2'd0 - n_q[1:0]) : n_q[1:0];
    end
  end

  // Square of the remainder
  logic [60:0] usq_d;
  side_t       side4_q;

  assign usq_d = 61'(u3_q) * 61'(u3_q) + (61'(1) << 29);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side4_q.x2   <= usq_d[59:30];
      side4_q.u    <= u3_q;
      side4_q.sneg <= sneg3_q;
      side4_q.quad <= quad3_q;
    end
  end

  // Horner steps, two stages each: multiply by x2, then divide by constant
  side_t       side_a_q [NS];
  side_t       side_b_q [NS];
  logic [29:0] vs_q [NS];
  logic [29:0] vc_q [NS];
  logic [30:0] ts_q [NS];
  logic [30:0] tc_q [NS];

  for (genvar j = 0; j < NS; j++) begin : g_step
    side_t       side_in;
    logic [30:0] ts_in, tc_in;
    logic [29:0] ms;
    logic [60:0] ps_d, pc_d, qs_d, qc_d;
    logic [30:0] ts_d, tc_d;

    if (j == 0) begin : g_first
      assign side_in = side4_q;
      assign ts_in   = scd_pkg::Q_ONE;
      assign tc_in   = scd_pkg::Q_ONE;
    end else begin : g_next
      assign side_in = side_b_q[j-1];
      assign ts_in   = ts_q[j-1];
      assign tc_in   = tc_q[j-1];
    end

    // last sine slot takes u * t instead of a further term
    if (j < NS - 1) begin : g_sx
      assign ms = side_in.x2;
    end else begin : g_su
      assign ms = side_in.u;
    end

    assign ps_d = 61'(ms) * 61'(ts_in);
    assign pc_d = 61'(side_in.x2) * 61'(tc_in);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_a_q[j] <= side_in;
        vs_q[j]     <= ps_d[59:30];
        vc_q[j]     <= pc_d[59:30];
      end
    end

    assign qc_d = (61'(vc_q[j]) * 61'(scd_pkg::COS_RECIP[j])) >> scd_pkg::COS_SHIFT[j];
    assign tc_d = scd_pkg::Q_ONE - qc_d[30:0];

    if (j < NS - 1) begin : g_sdiv
      assign qs_d = (61'(vs_q[j]) * 61'(scd_pkg::SIN_RECIP[j])) >> scd_pkg::SIN_SHIFT[j];
      assign ts_d = scd_pkg::Q_ONE - qs_d[30:0];
    end else begin : g_sout
      assign qs_d = 61'(vs_q[j]);
      assign ts_d = qs_d[30:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_b_q[j] <= side_a_q[j];
        ts_q[j]     <= ts_d;
        tc_q[j]     <= tc_d;
      end
    end
  end

  // Sign and quadrant rotation
  scd_pkg::q30_t s_mag, s_val, c_val, sin_d, cos_d, sin_q, cos_q;

  always_comb begin
    s_mag = {2'b00, ts_q[NS-1][29:0]};
    s_val = side_b_q[NS-1].sneg ? -s_mag : s_mag;
    c_val = {1'b0, tc_q[NS-1]};
    case (side_b_q[NS-1].quad)
      QUAD_REF: begin
        sin_d = s_val;
        cos_d = c_val;
      end
      QUAD_LEFT: begin
        sin_d = c_val;
        cos_d = -s_val;
      end
      QUAD_BACK: begin
        sin_d = -s_val;
        cos_d = -c_val;
      end
      QUAD_RIGHT: begin
        sin_d = -c_val;
        cos_d = s_val;
      end
      default: begin
        sin_d = s_val;
        cos_d = c_val;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

### hdl/scd_isqrt.sv
module scd_isqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [31:0]                 rad_i,
  output logic [scd_pkg::ROOT_W-1:0]  root_o
);

  localparam int unsigned NR = scd_pkg::ROOT_W;

  logic [32:0]   rem_q  [NR];
  logic [NR-1:0] root_q [NR];
  logic [31:0]   rad_q  [NR-1];

  // One root bit per stage; the operand is rad << 31
  for (genvar i = 0; i < NR; i++) begin : g_bit
    logic [32:0]   rem_in;
    logic [NR-1:0] root_in;
    logic [31:0]   rad_in;
    logic [63:0]   opnd;
    logic [34:0]   rem_sh, trial, rem_sub;
    logic          take;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
    end

    assign opnd    = {1'b0, rad_in, 31'b0};
    assign rem_sh  = {rem_in, opnd[63-2*i -: 2]};
    assign trial   = {1'b0, root_in, 2'b01};
    assign take    = rem_sh >= trial;
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= take ? rem_sub[32:0] : rem_sh[32:0];
        root_q[i] <= {root_in[NR-2:0], take};
      end
    end

    if (i < NR - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rad_q[i] <= rad_in;
        end
      end
    end
  end

  assign root_o = root_q[NR-1];

endmodule

### hdl/sphere_chord_distance.sv
// Channel  Direction  Width  Fields (lowest bit first)
// s_axis   in         104    first_latitude[23:0], first_longitude[48:24],
//                            second_latitude[72:49], second_longitude[97:73], zero pad
// m_axis   out        24     chord_length[21:0], zero pad
//
// One word per clock while the pipe is not frozen; every stage holds one point
// pair and a valid bit. After its word is accepted, a result passes the input
// stage, the sine/cosine pipes, the products, the one-bit-per-stage square root,
// the scaling and the output register.
// Reset clears the valid bits and the output valid only; data registers hold junk.
// A stalled output freezes the pipe, unless the stage before the output holds
// a bubble, which is dropped so the pipe keeps taking words.
module sphere_chord_distance (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // first_latitude, first_longitude, second_latitude, second_longitude, pad
  input  logic [scd_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // chord_length, pad
  output logic [scd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);

  localparam int unsigned DEPTH = scd_pkg::PIPE_DEPTH;

  // Flow control
  logic             out_load, adv, s_fire;
  logic [DEPTH-1:0] valid_q;
  logic             out_valid_q;

  assign out_load        = !out_valid_q || m_axis_tready_i;
  assign adv             = out_load || !valid_q[DEPTH-1];
  assign s_axis_tready_o = adv;
  assign s_fire          = s_axis_tvalid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        valid_q <= {valid_q[DEPTH-2:0], s_fire};
      end
      if (out_load) begin
        out_valid_q <= valid_q[DEPTH-1];
      end
    end
  end

  // Unpack the word and form the three angles: two polar angles and the
  // longitude difference, all in degrees*65536
  logic [scd_pkg::LAT_W-1:0] lat1, lat2;
  logic [scd_pkg::LON_W-1:0] lon1, lon2;
  logic signed [scd_pkg::ANG_W-1:0] th1_d, th2_d, dp_d, th1_q, th2_q, dp_q;

  assign lat1 = s_axis_tdata_i[23:0];
  assign lon1 = s_axis_tdata_i[48:24];
  assign lat2 = s_axis_tdata_i[72:49];
  assign lon2 = s_axis_tdata_i[97:73];

  assign th1_d = scd_pkg::POLAR_OFS - {{2{lat1[scd_pkg::LAT_W-1]}}, lat1};
  assign th2_d = scd_pkg::POLAR_OFS - {{2{lat2[scd_pkg::LAT_W-1]}}, lat2};
  assign dp_d  = {lon1[scd_pkg::LON_W-1], lon1} - {lon2[scd_pkg::LON_W-1], lon2};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      th1_q <= th1_d;
      th2_q <= th2_d;
      dp_q  <= dp_d;
    end
  end

  scd_pkg::q30_t s1, c1, s2, c2, sd, cd;

  scd_sincos u_sc_first (
    .clk_i   (clk_i),
    .en_i    (adv),
    .angle_i (th1_q),
    .sin_o   (s1),
    .cos_o   (c1)
  );

  scd_sincos u_sc_second (
    .clk_i   (clk_i),
    .en_i    (adv),
    .angle_i (th2_q),
    .sin_o   (s2),
    .cos_o   (c2)
  );

  scd_sincos u_sc_delta (
    .clk_i   (clk_i),
    .en_i    (adv),
    .angle_i (dp_q),
    .sin_o   (sd),
    .cos_o   (cd)
  );

  // Rounded Q30 product on magnitudes, sign applied after
  function automatic scd_pkg::q30_t mulq(scd_pkg::q30_t a, scd_pkg::q30_t b);
    logic [30:0]   ma, mb;
    logic [61:0]   p;
    scd_pkg::q30_t r;
    ma = a[31] ? 31'(-a) : 31'(a);
    mb = b[31] ? 31'(-b) : 31'(b);
    p  = 62'(ma) * 62'(mb) + (62'(1) << 29);
    r  = {1'b0, p[60:30]};
    return (a[31] ^ b[31]) ? -r : r;
  endfunction

  // Cosine of the central angle, in two product stages
  scd_pkg::q30_t ss_q, cc_q, cd_q, sss_q, cc2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ss_q  <= mulq(s1, s2);
      cc_q  <= mulq(c1, c2);
      cd_q  <= cd;
      sss_q <= mulq(ss_q, cd_q);
      cc2_q <= cc_q;
    end
  end

  // 1 - cos, clamped at zero against rounding
  logic signed [33:0] inner_d, diff_d;
  logic [31:0]        rad_q;

  assign inner_d = 34'(sss_q) + 34'(cc2_q);
  assign diff_d  = (34'sd1 <<< 30) - inner_d;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad_q <= diff_d[33] ? 32'd0 : diff_d[31:0];
    end
  end

  logic [scd_pkg::ROOT_W-1:0] root;

  scd_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (rad_q),
    .root_o (root)
  );

  // Scale to km*256: multiply by radius, then divide by 1000 * 2^22 as
  // a shift by 25 and a reciprocal multiply for the remaining 125
  logic [55:0] x_q;
  logic [60:0] z_q;
  logic [23:0] d_raw;
  logic [scd_pkg::CHORD_W-1:0] chord_d, chord_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q <= 56'(root) * 56'(scd_pkg::OUT_SCALE) + 56'(scd_pkg::OUT_BIAS);
      z_q <= 61'(x_q[54:25]) * 61'(scd_pkg::OUT_RECIP);
    end
  end

  assign d_raw   = 24'(z_q >> scd_pkg::OUT_SHIFT);
  assign chord_d = (d_raw[23:22] != 2'b00) ? scd_pkg::CHORD_MAX : d_raw[21:0];

  // Output register: load when empty or taken, hold otherwise
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      chord_q <= chord_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, chord_q};

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int LAT_MAX = 5898240;
  localparam int LON_MAX = 11796480;
  localparam int N_RANDOM = 400;
  localparam int STALL_LIMIT = 20000;
  localparam int PIPE_LAT = 59;

  typedef struct packed {
    logic signed [scd_pkg::LON_W-1:0] lon2;
    logic signed [scd_pkg::LAT_W-1:0] lat2;
    logic signed [scd_pkg::LON_W-1:0] lon1;
    logic signed [scd_pkg::LAT_W-1:0] lat1;
  } pair_t;

  // One directed row: a point pair and, where obvious, the expected chord.
  typedef struct {
    pair_t pair;
    bit    has_known;
    int    known;
  } vec_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid_i, s_axis_tready_o;
  logic [scd_pkg::IN_TDATA_W-1:0] s_axis_tdata_i;
  logic m_axis_tvalid_o, m_axis_tready_i;
  logic [scd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;

  sphere_chord_distance uut (.*);

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  logic [scd_pkg::CHORD_W-1:0] chord_q[$];
  int  n_errors;
  int  idle_cycles;
  bit  stim_done;
  bit  hold_rx;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // ---- chord predictor ----
  function automatic longint mag(input longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic longint q30_mul(input longint a, input longint b);
    longint unsigned p;
    p = (longint'(mag(a)) * mag(b) + (64'd1 << 29)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint deg_to_rad(input longint deg);
    longint unsigned p;
    p = (longint'(mag(deg)) * 64'd19190106293 + (64'd1 << 25)) >> 26;
    return deg < 0 ? -longint'(p) : longint'(p);
  endfunction

  function automatic void trig(input longint ang, output longint sn, output longint cs);
    longint unsigned m, n, u, x2, t;
    longint r, s, c;
    int qd;
    m = mag(ang);
    n = (m + scd_pkg::HALF_PI_Q30 / 2) / scd_pkg::HALF_PI_Q30;
    r = longint'(m) - longint'(n * scd_pkg::HALF_PI_Q30);
    qd = int'(n & 3);
    if (ang < 0) begin
      r = -r;
      qd = (4 - qd) & 3;
    end
    u = mag(r);
    x2 = (u * u + (64'd1 << 29)) >> 30;
    t = 64'd1 << 30;
    for (int k = 12; k >= 2; k -= 2)
      t = (64'd1 << 30) - ((x2 * t) >> 30) / longint'(k * (k + 1));
    s = longint'((u * t) >> 30);
    if (r < 0) s = -s;
    t = 64'd1 << 30;
    for (int k = 14; k >= 2; k -= 2)
      t = (64'd1 << 30) - ((x2 * t) >> 30) / longint'((k - 1) * k);
    c = longint'(t);
    case (qd)
      0: begin sn = s;  cs = c;  end
      1: begin sn = c;  cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [scd_pkg::CHORD_W-1:0] chord_of(input pair_t p);
    longint s1, c1, s2, c2, sd, cd, m;
    longint unsigned q, d;
    trig(deg_to_rad(longint'(LAT_MAX) - longint'(p.lat1)), s1, c1);
    trig(deg_to_rad(longint'(LAT_MAX) - longint'(p.lat2)), s2, c2);
    trig(deg_to_rad(longint'(p.lon1) - longint'(p.lon2)), sd, cd);
    m = (64'sd1 <<< 30) - (q30_mul(q30_mul(s1, s2), cd) + q30_mul(c1, c2));
    if (m < 0) m = 0;   // clamp a rounding-negative radicand
    q = int_sqrt((longint'(m) * 2) << 30);
    d = (q * 64'd6356752 + 64'd2097152000) / 64'd4194304000;
    if (d > 64'd4194303) d = 64'd4194303;
    return d[scd_pkg::CHORD_W-1:0];
  endfunction

  function automatic pair_t mk(input int a, input int b, input int c, input int d);
    pair_t p;
    p.lat1 = a[scd_pkg::LAT_W-1:0];
    p.lon1 = b[scd_pkg::LON_W-1:0];
    p.lat2 = c[scd_pkg::LAT_W-1:0];
    p.lon2 = d[scd_pkg::LON_W-1:0];
    return p;
  endfunction

  // Random pair: mostly legal coordinates, some raw field patterns.
  function automatic pair_t rand_pair();
    pair_t p;
    logic [127:0] raw;
    if ($urandom_range(9) == 0) begin
      raw = {$urandom, $urandom, $urandom, $urandom};
      p = raw[$bits(pair_t)-1:0];
    end else begin
      p = mk(int'($urandom_range(2 * LAT_MAX)) - LAT_MAX,
             int'($urandom_range(2 * LON_MAX)) - LON_MAX,
             int'($urandom_range(2 * LAT_MAX)) - LAT_MAX,
             int'($urandom_range(2 * LON_MAX)) - LON_MAX);
    end
    return p;
  endfunction

  // Drive one word and hold it until the block takes it.
  task automatic send_word(input pair_t p);
    logic [scd_pkg::IN_TDATA_W-1:0] w;
    w = '0;
    w[$bits(pair_t)-1:0] = p;
    s_axis_tdata_i  <= w;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    chord_q.push_back(chord_of(p));
  endtask

  task automatic drop_valid();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---- sender ----
  initial begin
    vec_t dir[$];
    int   burst;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    stim_done = 1'b0;
    hold_rx = 1'b0;
    n_errors = 0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Same point twice must give zero; antipodes, which give the diameter, are checked against the predictor only.
    dir.push_back('{mk(0, 0, 0, 0), 1, 0});
    dir.push_back('{mk(LAT_MAX, 0, LAT_MAX, 0), 1, 0});
    dir.push_back('{mk(LAT_MAX, 0, -LAT_MAX, 0), 0, 0});
    dir.push_back('{mk(0, 0, 0, LON_MAX), 0, 0});
    dir.push_back('{mk(0, LON_MAX, 0, -LON_MAX), 1, 0});
    dir.push_back('{mk(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX), 0, 0});
    dir.push_back('{mk(0, 5898240, 0, 0), 0, 0});
    dir.push_back('{mk(3276800, 1000, 3276800, 1001), 0, 0});     // near-equal: clamp path
    dir.push_back('{mk(1, 1, 0, 0), 0, 0});
    dir.push_back('{mk(-8388608, -16777216, 8388607, 16777215), 0, 0}); // raw field extremes
    dir.push_back('{mk(8388607, 16777215, -8388608, -16777216), 0, 0});
    dir.push_back('{mk(-1, -1, -1, -1), 1, 0});
    dir.push_back('{mk(4000000, -9000000, -2500000, 7000000), 0, 0});
    foreach (dir[i]) begin
      send_word(dir[i].pair);
      if (dir[i].has_known && chord_q[$] != dir[i].known)
        report_mismatch("directed table", chord_q[$], dir[i].known);
    end
    drop_valid();

    // Fill the pipe while the receiver holds off.
    hold_rx = 1'b1;
    for (int i = 0; i < 80; i++) send_word(rand_pair());
    drop_valid();
    hold_rx = 1'b0;

    // Pause until the pipe drains completely.
    while (chord_q.size() != 0) @(posedge clk_i);

    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && n < N_RANDOM; i++, n++) send_word(rand_pair());
      if ($urandom_range(3) != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // ---- receiver: random stalls, stretches of none, and one long hold-off ----
  initial begin
    int hold_cnt;
    int mode;
    int len;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      mode = $urandom_range(2);
      len = $urandom_range(5, 60);
      for (int i = 0; i < len && !(hold_rx && !held); i++) begin
        m_axis_tready_i <= (mode == 0) ? 1'b1 : ($urandom_range(mode) == 0);
        @(posedge clk_i);
      end
      if (hold_rx && !held) begin
        held = 1'b1;
        hold_cnt = 0;
        m_axis_tready_i <= 1'b0;
        while (hold_cnt < 300) begin
          @(posedge clk_i);
          hold_cnt++;
        end
      end
    end
  end

  // ---- result check ----
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (chord_q.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata_o[scd_pkg::CHORD_W-1:0], -1);
      end else begin
        if (m_axis_tdata_o[scd_pkg::CHORD_W-1:0] !== chord_q[0])
          report_mismatch("chord_length", m_axis_tdata_o[scd_pkg::CHORD_W-1:0], chord_q[0]);
        void'(chord_q.pop_front());
      end
    end
  end

  // ---- watchdog and end of run ----
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
      if (stim_done && chord_q.size() == 0) begin
        repeat (2 * PIPE_LAT) @(posedge clk_i);
        if (n_errors == 0 && chord_q.size() == 0) begin
          $display("Test completed successfully");
        end else begin
          $display("Test completed with failures");
        end
        $finish;
      end
    end
  end

endmodule

### sphere_chord_distance.f
hdl/scd_pkg.sv
hdl/scd_sincos.sv
hdl/scd_isqrt.sv
hdl/sphere_chord_distance.sv
tb/tb_top.sv
